FILE: hw/rtl/pgfw_pkg.sv
// Shared constants and codes for the pixel and glyph frame writer.
package pgfw_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned SCREEN_WIDTH_DEF  = 640;
	localparam int unsigned SCREEN_HEIGHT_DEF = 480;
	localparam int unsigned GLYPH_ROWS_DEF    = 8;

	// Fixed field widths
	localparam int unsigned STORE_AW   = 11;
	localparam int unsigned STORE_DEPTH = 2048;
	localparam int unsigned ADDR_W     = 19;
	localparam int unsigned COORD_W    = 10;
	localparam int unsigned GLYPH_COLS = 8;
	localparam int unsigned COL_W      = 3;

	// Item kinds
	typedef enum logic [1:0] {
		FUNC_PIXEL = 2'd0,
		FUNC_CHAR  = 2'd1,
		FUNC_DRAW  = 2'd2,
		FUNC_LOAD  = 2'd3
	} func_t;

	// Opcodes, upper six bits of the command word
	localparam logic [5:0] OP_PIX_WRITE = 6'h2C;
	localparam logic [5:0] OP_PIX_COL   = 6'h2D;
	localparam logic [5:0] OP_PIX_ROW   = 6'h2E;
	localparam logic [5:0] OP_CHR_COL   = 6'h31;
	localparam logic [5:0] OP_CHR_ROW   = 6'h32;

endpackage

FILE: hw/rtl/pgfw_ram.sv
// Generic single-port RAM with registered read data.
module pgfw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: hw/rtl/pixel_and_glyph_frame_writer.sv
// Top level: command decode, cursor, glyph expansion over the glyph store RAM.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------------------
//  in      | in  | in_valid / in_ready | func, command_word, char_x, char_y, char_code,
//          |     |                     | fore_color, back_color, glyph_index, glyph_bits
//  out     | out | out_valid/out_ready | pixel_address, pixel_color, last_write
//
// Pixel and char command words and glyph loads are handled in the idle state; pixel writes
// stream one per cycle while the output is taken.
// A draw-character item holds the input until it is done: each row reads the glyph store
// in S_WAIT and captures the byte in S_ROW, then walks its columns one per cycle while
// no output stall holds the walk, and a final flush in S_FLUSH follows the last row.
// The glyph store is a single-port RAM; loads and draw reads share its one port.
// Output stalls hold the column walk once a pixel is waiting; reset clears the cursor
// and control state only, the glyph store keeps whatever it holds.
module pixel_and_glyph_frame_writer #(
	parameter int unsigned SCREEN_WIDTH  = pgfw_pkg::SCREEN_WIDTH_DEF,
	parameter int unsigned SCREEN_HEIGHT = pgfw_pkg::SCREEN_HEIGHT_DEF,
	parameter int unsigned GLYPH_ROWS    = pgfw_pkg::GLYPH_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [15:0] command_word,
	input  logic signed [15:0] char_x,
	input  logic signed [15:0] char_y,
	input  logic [7:0]  char_code,
	input  logic [7:0]  fore_color,
	input  logic [7:0]  back_color,
	input  logic [10:0] glyph_index,
	input  logic [7:0]  glyph_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [18:0] pixel_address,
	output logic [7:0]  pixel_color,
	output logic        last_write
);

	localparam int unsigned RW = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
	localparam int unsigned CW = pgfw_pkg::COORD_W;
	localparam int unsigned AW = pgfw_pkg::ADDR_W;
	localparam int unsigned SW = pgfw_pkg::STORE_AW;
	localparam logic [CW-1:0] WIDTH_C  = CW'(SCREEN_WIDTH);
	localparam logic [CW-1:0] HEIGHT_C = CW'(SCREEN_HEIGHT);
	localparam logic [RW-1:0] ROW_LAST = RW'(GLYPH_ROWS - 1);
	localparam logic [pgfw_pkg::COL_W-1:0] COL_LAST = pgfw_pkg::COL_W'(pgfw_pkg::GLYPH_COLS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WAIT,
		S_ROW,
		S_COL,
		S_FLUSH
	} state_t;

	state_t state_q;

	// Control registers
	logic                        out_valid_q;
	logic                        pend_v_q;
	logic [CW-1:0]               cursor_col_q;
	logic [CW-1:0]               cursor_row_q;
	logic [RW-1:0]               row_q;
	logic [pgfw_pkg::COL_W-1:0]  col_q;

	// Payload registers
	logic [AW-1:0]        pixel_address_q;
	logic [7:0]           pixel_color_q;
	logic                 last_write_q;
	logic [AW-1:0]        pend_addr_q;
	logic [7:0]           pend_color_q;
	logic signed [15:0]   x0_q;
	logic signed [15:0]   y0_q;
	logic [7:0]           fg_q;
	logic [7:0]           bg_q;
	logic [7:0]           line_q;
	logic [AW-1:0]        rowbase_q;
	logic                 row_ok_q;
	logic [SW-1:0]        rd_addr_q;

	// RAM port
	logic          ram_we;
	logic [SW-1:0] ram_addr;
	logic [7:0]    ram_rdata;

	// Decode and handshake
	logic       out_free;
	logic       accept;
	logic [5:0] op;
	logic       do_write;
	logic       on_screen;
	logic       cmd_emit;
	logic [19:0] cmd_prod;
	logic [AW-1:0] cmd_addr;
	logic [CW-1:0] col_inc;
	logic [SW-1:0] draw_base;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign op        = command_word[15:10];
	assign do_write  = accept && (func == pgfw_pkg::FUNC_PIXEL) && (op == pgfw_pkg::OP_PIX_WRITE);
	assign on_screen = (cursor_col_q < WIDTH_C) && (cursor_row_q < HEIGHT_C);
	assign cmd_emit  = do_write && on_screen;
	assign cmd_prod  = {10'b0, cursor_row_q} * {10'b0, WIDTH_C};
	assign cmd_addr  = cmd_prod[AW-1:0] + {{(AW-CW){1'b0}}, cursor_col_q};
	assign col_inc   = cursor_col_q + CW'(1);
	assign draw_base = SW'({3'b000, char_code} * SW'(GLYPH_ROWS));

	// Glyph pixel at the current row and column
	logic signed [16:0] x_full;
	logic signed [16:0] y_full;
	logic               x_ok;
	logic               y_ok;
	logic [19:0]        row_prod;
	logic               pix_bit;
	logic               want;
	logic [AW-1:0]      pix_addr;
	logic [7:0]         pix_color;

	assign x_full    = {x0_q[15], x0_q} + {{(17-pgfw_pkg::COL_W){1'b0}}, col_q};
	assign y_full    = {y0_q[15], y0_q} + {{(17-RW){1'b0}}, row_q};
	assign x_ok      = !x_full[16] && (x_full[15:0] < 16'(SCREEN_WIDTH));
	assign y_ok      = !y_full[16] && (y_full[15:0] < 16'(SCREEN_HEIGHT));
	assign row_prod  = {10'b0, y_full[CW-1:0]} * {10'b0, WIDTH_C};
	assign pix_bit   = line_q[col_q];
	assign want      = row_ok_q && x_ok && (pix_bit || (bg_q != fg_q));
	assign pix_addr  = rowbase_q + {{(AW-CW){1'b0}}, x_full[CW-1:0]};
	assign pix_color = pix_bit ? fg_q : bg_q;

	// Column walk moves on unless a pixel waits behind a full pending slot that the output cannot take
	logic col_go;
	logic push_pend;
	logic flush_push;
	logic out_load;
	logic pend_load;
	logic col_end;

	assign col_go     = (state_q == S_COL) && (!want || !pend_v_q || out_free);
	assign push_pend  = (state_q == S_COL) && want && pend_v_q && out_free;
	assign flush_push = (state_q == S_FLUSH) && pend_v_q && out_free;
	assign out_load   = cmd_emit || push_pend || flush_push;
	assign pend_load  = col_go && want;
	assign col_end    = col_go && (col_q == COL_LAST);

	assign ram_we   = accept && (func == pgfw_pkg::FUNC_LOAD);
	assign ram_addr = (state_q == S_IDLE) ? glyph_index : rd_addr_q;

	pgfw_ram #(
		.WIDTH (8),
		.DEPTH (pgfw_pkg::STORE_DEPTH)
	) u_glyph_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (glyph_bits),
		.rdata (ram_rdata)
	);

	// State machine, cursor and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			pend_v_q     <= 1'b0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			row_q        <= '0;
			col_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (pend_load) begin
				pend_v_q <= 1'b1;
			end else if (flush_push) begin
				pend_v_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == pgfw_pkg::FUNC_PIXEL) begin
							if (op == pgfw_pkg::OP_PIX_WRITE) begin
								if (col_inc >= WIDTH_C) begin
									cursor_col_q <= '0;
									cursor_row_q <= cursor_row_q + CW'(1);
								end else begin
									cursor_col_q <= col_inc;
								end
							end else if (op == pgfw_pkg::OP_PIX_COL) begin
								cursor_col_q <= command_word[CW-1:0];
							end else if (op == pgfw_pkg::OP_PIX_ROW) begin
								cursor_row_q <= command_word[CW-1:0];
							end
						end else if (func == pgfw_pkg::FUNC_CHAR) begin
							if (op == pgfw_pkg::OP_CHR_COL) begin
								cursor_col_q <= command_word[CW-1:0];
							end else if (op == pgfw_pkg::OP_CHR_ROW) begin
								cursor_row_q <= command_word[CW-1:0];
							end
						end else if (func == pgfw_pkg::FUNC_DRAW) begin
							row_q   <= '0;
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					state_q <= S_ROW;
				end
				S_ROW: begin
					col_q   <= '0;
					state_q <= S_COL;
				end
				S_COL: begin
					if (col_go) begin
						col_q <= col_q + 1'b1;
						if (col_end) begin
							if (row_q == ROW_LAST) begin
								state_q <= S_FLUSH;
							end else begin
								row_q   <= row_q + 1'b1;
								state_q <= S_WAIT;
							end
						end
					end
				end
				S_FLUSH: begin
					if (!pend_v_q || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_address_q <= cmd_emit ? cmd_addr : pend_addr_q;
			pixel_color_q   <= cmd_emit ? command_word[7:0] : pend_color_q;
			last_write_q    <= cmd_emit || flush_push;
		end
		if (pend_load) begin
			pend_addr_q  <= pix_addr;
			pend_color_q <= pix_color;
		end
		if (accept && (func == pgfw_pkg::FUNC_DRAW)) begin
			x0_q      <= char_x;
			y0_q      <= char_y;
			fg_q      <= fore_color;
			bg_q      <= back_color;
			rd_addr_q <= draw_base;
		end else if (col_end) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end
		if (state_q == S_ROW) begin
			line_q    <= ram_rdata;
			rowbase_q <= row_prod[AW-1:0];
			row_ok_q  <= y_ok;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_address = pixel_address_q;
	assign pixel_color   = pixel_color_q;
	assign last_write    = last_write_q;

	// The pending slot is empty whenever a new item can start
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("pending pixel left over in idle");

	// A final beat never leaves a pixel behind it
	a_last_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_write_q) |-> !pend_v_q)
		else $error("last beat shown while a pixel is pending");

	// Row change steps the glyph store address by one
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		(col_end && (row_q != ROW_LAST)) |=>
		((state_q == S_WAIT) && (rd_addr_q == $past(rd_addr_q) + 1'b1)))
		else $error("glyph row address did not advance");

	// A glyph store read is always followed by its capture
	a_wait_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT) |=> (state_q == S_ROW))
		else $error("glyph row read not captured");

endmodule

FILE: sim/pixel_and_glyph_frame_writer_test.sv
// Self-checking testbench for the pixel and glyph frame writer: directed and random command beats.
module pixel_and_glyph_frame_writer_test;

	localparam int SCREEN_W = int'(pgfw_pkg::SCREEN_WIDTH_DEF);
	localparam int SCREEN_H = int'(pgfw_pkg::SCREEN_HEIGHT_DEF);
	localparam int GLYPH_H = int'(pgfw_pkg::GLYPH_ROWS_DEF);
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAW_CYCLES = GLYPH_H * 10 + 1;
	localparam int RANDOM_PER_PHASE = 28;

	// One input beat, all fields
	typedef struct {
		pgfw_pkg::func_t kind;
		logic [15:0] word;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [7:0] code;
		logic [7:0] fg;
		logic [7:0] bg;
		logic [10:0] gidx;
		logic [7:0] gbits;
	} frame_cmd_t;

	// One frame buffer write
	typedef struct packed {
		logic [pgfw_pkg::ADDR_W-1:0] addr;
		logic [7:0] color;
		logic tail;
	} pixel_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = '0;
	logic [15:0] command_word = '0;
	logic signed [15:0] char_x = '0;
	logic signed [15:0] char_y = '0;
	logic [7:0] char_code = '0;
	logic [7:0] fore_color = '0;
	logic [7:0] back_color = '0;
	logic [10:0] glyph_index = '0;
	logic [7:0] glyph_bits = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [18:0] pixel_address;
	logic [7:0] pixel_color;
	logic last_write;

	frame_cmd_t cmd_backlog[$];
	frame_cmd_t held_cmd;
	pixel_write_t pixel_writes_due[$];
	int drawable_codes[$];

	// Shadow of the block's cursor and glyph store
	logic [pgfw_pkg::COORD_W-1:0] cur_col = '0;
	logic [pgfw_pkg::COORD_W-1:0] cur_row = '0;
	logic [7:0] glyph_mem [pgfw_pkg::STORE_DEPTH];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int bad_writes = 0;
	int quiet_cycles = 0;

	pixel_and_glyph_frame_writer #(
		.SCREEN_WIDTH (pgfw_pkg::SCREEN_WIDTH_DEF),
		.SCREEN_HEIGHT(pgfw_pkg::SCREEN_HEIGHT_DEF),
		.GLYPH_ROWS   (pgfw_pkg::GLYPH_ROWS_DEF)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.command_word (command_word),
		.char_x       (char_x),
		.char_y       (char_y),
		.char_code    (char_code),
		.fore_color   (fore_color),
		.back_color   (back_color),
		.glyph_index  (glyph_index),
		.glyph_bits   (glyph_bits),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_address(pixel_address),
		.pixel_color  (pixel_color),
		.last_write   (last_write)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Work out the writes one accepted beat causes and update the shadow state
	function automatic void render_cmd(input frame_cmd_t c);
		logic [5:0] op;
		logic [9:0] arg;
		logic [7:0] line;
		pixel_write_t w;
		pixel_write_t batch[$];
		int px;
		int py;
		op = c.word[15:10];
		arg = c.word[9:0];
		case (c.kind)
			pgfw_pkg::FUNC_PIXEL: begin
				if (op == pgfw_pkg::OP_PIX_WRITE) begin
					// off-frame cursor drops the write but still advances
					if (cur_col < SCREEN_W && cur_row < SCREEN_H) begin
						w.addr = pgfw_pkg::ADDR_W'(int'(cur_row) * SCREEN_W +
							int'(cur_col));
						w.color = arg[7:0];
						w.tail = 1'b0;
						batch.push_back(w);
					end
					cur_col = cur_col + 10'd1;
					if (cur_col >= SCREEN_W) begin
						cur_col = '0;
						cur_row = cur_row + 10'd1;
					end
				end else if (op == pgfw_pkg::OP_PIX_COL) begin
					cur_col = arg;
				end else if (op == pgfw_pkg::OP_PIX_ROW) begin
					cur_row = arg;
				end
			end
			pgfw_pkg::FUNC_CHAR: begin
				if (op == pgfw_pkg::OP_CHR_COL)
					cur_col = arg;
				else if (op == pgfw_pkg::OP_CHR_ROW)
					cur_row = arg;
			end
			pgfw_pkg::FUNC_DRAW: begin
				// row by row, bit 0 leftmost, clipped to the screen
				for (int i = 0; i < GLYPH_H; i++) begin
					line = glyph_mem[pgfw_pkg::STORE_AW'(int'(c.code) * GLYPH_H + i)];
					for (int j = 0; j < pgfw_pkg::GLYPH_COLS; j++) begin
						px = int'(c.x) + j;
						py = int'(c.y) + i;
						if ((line[j] || c.bg != c.fg) && px >= 0 && py >= 0 &&
								px < SCREEN_W && py < SCREEN_H) begin
							w.addr = pgfw_pkg::ADDR_W'(py * SCREEN_W + px);
							w.color = line[j] ? c.fg : c.bg;
							w.tail = 1'b0;
							batch.push_back(w);
						end
					end
				end
			end
			default: begin
				glyph_mem[c.gidx] = c.gbits;
			end
		endcase
		if (batch.size() != 0)
			batch[batch.size() - 1].tail = 1'b1;
		foreach (batch[k])
			pixel_writes_due.push_back(batch[k]);
	endfunction

	function automatic frame_cmd_t random_cmd();
		frame_cmd_t c;
		c.kind = pgfw_pkg::func_t'($urandom_range(3));
		c.word = 16'($urandom);
		c.x = 16'($urandom);
		c.y = 16'($urandom);
		c.code = 8'($urandom);
		c.fg = 8'($urandom);
		c.bg = 8'($urandom);
		c.gidx = 11'($urandom);
		c.gbits = 8'($urandom);
		return c;
	endfunction

	function automatic frame_cmd_t word_cmd(input pgfw_pkg::func_t kind,
			input logic [5:0] op, input logic [9:0] arg);
		frame_cmd_t c;
		c = random_cmd();
		c.kind = kind;
		c.word = {op, arg};
		return c;
	endfunction

	function automatic frame_cmd_t draw_cmd(input int xv, input int yv, input logic [7:0] code,
			input logic [7:0] fg, input logic [7:0] bg);
		frame_cmd_t c;
		c = random_cmd();
		c.kind = pgfw_pkg::FUNC_DRAW;
		c.x = xv[15:0];
		c.y = yv[15:0];
		c.code = code;
		c.fg = fg;
		c.bg = bg;
		return c;
	endfunction

	function automatic frame_cmd_t load_cmd(input logic [10:0] idx, input logic [7:0] bits);
		frame_cmd_t c;
		c = random_cmd();
		c.kind = pgfw_pkg::FUNC_LOAD;
		c.gidx = idx;
		c.gbits = bits;
		return c;
	endfunction

	// Load every row of one glyph; only fully loaded glyphs are ever drawn
	function automatic void queue_glyph(input logic [7:0] code, input logic [63:0] rows);
		for (int i = 0; i < GLYPH_H; i++)
			cmd_backlog.push_back(load_cmd(
				pgfw_pkg::STORE_AW'(int'(code) * GLYPH_H + i), rows[8*i +: 8]));
		drawable_codes.push_back(int'(code));
	endfunction

	// Extremes of the cursor and draw fields, every opcode, ignored codes
	task automatic queue_directed();
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_PIX_WRITE,
			10'h3FF));
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_PIX_COL,
			10'd639));
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_PIX_ROW,
			10'd479));
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_PIX_WRITE,
			10'h000));
		// cursor now below the frame: write dropped
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_PIX_WRITE,
			10'h0AA));
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_CHAR, pgfw_pkg::OP_CHR_COL,
			10'h3FF));
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_CHAR, pgfw_pkg::OP_CHR_ROW,
			10'h3FF));
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_PIX_WRITE,
			10'h111));
		// advance past the width wraps the row from 1023 to 0
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_PIX_COL,
			10'd639));
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_PIX_WRITE,
			10'h222));
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_PIX_WRITE,
			10'h155));
		// opcodes in the wrong word kind, and unknown ones
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_CHR_COL,
			10'd5));
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_CHAR, pgfw_pkg::OP_PIX_WRITE,
			10'h3FF));
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_PIXEL, 6'h3F, 10'h3FF));
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_CHAR, 6'h00, 10'h000));
		cmd_backlog.push_back(word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_PIX_WRITE,
			10'h0C3));
		queue_glyph(8'hFF, 64'hF00F_55AA_8001_FF00);
		cmd_backlog.push_back(draw_cmd(632, 472, 8'hFF, 8'h00, 8'hFF));
		// equal colors: clear bits write nothing
		cmd_backlog.push_back(draw_cmd(-3, -5, 8'hFF, 8'h80, 8'h80));
		cmd_backlog.push_back(draw_cmd(-32768, -32768, 8'hFF, 8'h12, 8'h34));
		cmd_backlog.push_back(draw_cmd(32767, 32767, 8'hFF, 8'h12, 8'h34));
		cmd_backlog.push_back(draw_cmd(633, 473, 8'hFF, 8'h12, 8'h34));
	endtask

	// Random mix: glyph loads, draws, cursor traffic, noise
	task automatic queue_random_mix(input int count);
		frame_cmd_t c;
		int made;
		int pick;
		int mode;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(99);
			if (pick < 8 || drawable_codes.size() == 0) begin
				queue_glyph(8'($urandom), {$urandom, $urandom});
				made += GLYPH_H;
			end else if (pick < 33) begin
				c = random_cmd();
				c.kind = pgfw_pkg::FUNC_DRAW;
				c.code = 8'(drawable_codes[$urandom_range(drawable_codes.size() - 1)]);
				mode = $urandom_range(3);
				if (mode < 2) begin
					c.x = 16'($urandom_range(SCREEN_W - 1));
					c.y = 16'($urandom_range(SCREEN_H - 1));
				end else if (mode == 2) begin
					c.x = 16'(int'($urandom_range(SCREEN_W + 13)) - 7);
					c.y = 16'(int'($urandom_range(SCREEN_H + 13)) - 7);
				end
				if ($urandom_range(3) == 0)
					c.bg = c.fg;
				cmd_backlog.push_back(c);
				made++;
			end else if (pick < 68) begin
				mode = $urandom_range(9);
				if (mode < 6)
					c = word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_PIX_WRITE,
						10'($urandom));
				else if (mode < 8)
					c = word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_PIX_COL,
						10'($urandom_range($urandom_range(1) ? SCREEN_W - 1 : 1023)));
				else
					c = word_cmd(pgfw_pkg::FUNC_PIXEL, pgfw_pkg::OP_PIX_ROW,
						10'($urandom_range($urandom_range(1) ? SCREEN_H - 1 : 1023)));
				cmd_backlog.push_back(c);
				made++;
			end else if (pick < 78) begin
				if ($urandom_range(1))
					c = word_cmd(pgfw_pkg::FUNC_CHAR, pgfw_pkg::OP_CHR_COL,
						10'($urandom_range(SCREEN_W - 4, 1023)));
				else
					c = word_cmd(pgfw_pkg::FUNC_CHAR, pgfw_pkg::OP_CHR_ROW,
						10'($urandom_range(SCREEN_H - 1)));
				cmd_backlog.push_back(c);
				made++;
			end else begin
				// raw words of either kind, or a stray glyph byte
				c = random_cmd();
				if (c.kind == pgfw_pkg::FUNC_DRAW)
					c.kind = pgfw_pkg::FUNC_LOAD;
				cmd_backlog.push_back(c);
				made++;
			end
		end
	endtask

	// Hold off new beats until everything queued has been taken and written
	task automatic drain();
		while (cmd_backlog.size() != 0 || in_valid || pixel_writes_due.size() != 0)
			@(negedge clk);
	endtask

	// Input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				render_cmd(held_cmd);
			if (!in_valid || in_ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					held_cmd = cmd_backlog.pop_front();
					in_valid <= 1'b1;
					func <= held_cmd.kind;
					command_word <= held_cmd.word;
					char_x <= held_cmd.x;
					char_y <= held_cmd.y;
					char_code <= held_cmd.code;
					fore_color <= held_cmd.fg;
					back_color <= held_cmd.bg;
					glyph_index <= held_cmd.gidx;
					glyph_bits <= held_cmd.gbits;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor and checker
	always @(posedge clk) begin
		pixel_write_t w;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pixel_writes_due.size() == 0) begin
					bad_writes++;
					if (bad_writes <= 10)
						$display("unexpected write: addr %0d color %02h last %0b",
							pixel_address, pixel_color, last_write);
				end else begin
					w = pixel_writes_due.pop_front();
					if (pixel_address !== w.addr || pixel_color !== w.color ||
							last_write !== w.tail) begin
						bad_writes++;
						if (bad_writes <= 10)
							$display("write mismatch: expected addr %0d color %02h last %0b, %s",
								w.addr, w.color, w.tail,
								$sformatf("got addr %0d color %02h last %0b",
									pixel_address, pixel_color, last_write));
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: too long with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		queue_directed();
		drain();
		// code 0 reaches the bottom of the glyph store
		queue_glyph(8'h00, {$urandom, $urandom});
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 71 : 15) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 71 : 15) : 0;
			queue_random_mix(RANDOM_PER_PHASE);
			drain();
		end
		repeat (DRAW_CYCLES + 20) @(negedge clk);
		if (bad_writes == 0 && pixel_writes_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/pgfw_pkg.sv
hw/rtl/pgfw_ram.sv
hw/rtl/pixel_and_glyph_frame_writer.sv
sim/pixel_and_glyph_frame_writer_test.sv
